@@ rtl/xte_pkg.sv @@
// Package: shared types and constants of the XML text escaper.
package xte_pkg;

  localparam int unsigned ExpMax       = 6;
  localparam int unsigned CntW         = 3;
  localparam logic [15:0] CapReset     = 16'd1024;
  localparam logic [16:0] StopMargin   = 17'd7;
  localparam int unsigned QDepthDef    = 2;

  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChLt   = 8'h3C;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChTab  = 8'h09;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChSpc  = 8'h20;

  // One classified item: the bytes it emits, how many, and the stop flag.
  typedef struct packed {
    logic [ExpMax-1:0][7:0] bytes;
    logic [CntW-1:0]        cnt;
    logic                   stop;
  } xte_job_t;

endpackage

@@ rtl/xte_if.sv @@
// Interfaces: input byte channel and escaped output channel.
interface xte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_start;
  modport source(output valid, in_byte, string_start, input ready);
  modport sink(input valid, in_byte, string_start, output ready);
endinterface

interface xte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       capacity_reached;
  modport source(output valid, out_byte, run_last, capacity_reached, input ready);
  modport sink(input valid, out_byte, run_last, capacity_reached, output ready);
endinterface

@@ rtl/xml_text_escaper_unit.sv @@
// XML text escaper top level: front end, item queue and back end.
// An accepted input beat passes through the item queue and the back end output register.
// Throughput: one output beat per cycle while out_o.ready holds; an input byte
// expanding to N bytes holds the back end for N beats; the queue fills, stalls input.
// Plain bytes and dropped bytes go at one per cycle while the queue has room.
// Reset: count and stop flag clear, capacity returns to 1024, queue empties.
module xml_text_escaper_unit #(
  parameter int unsigned QDepth = xte_pkg::QDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  xte_in_if.sink      in_i,
  xte_out_if.source   out_o
);
  import xte_pkg::*;

  logic     q_ready, q_push, q_pop, head_valid;
  xte_job_t push_job, head_job;

  xte_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_ready_i   (q_ready),
    .q_push_o    (q_push),
    .q_job_o     (push_job)
  );

  xte_fifo #(.Depth(QDepth)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_job_i   (push_job),
    .ready_o      (q_ready),
    .pop_i        (q_pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  xte_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (q_pop),
    .out_o        (out_o)
  );

endmodule

@@ rtl/xte_front.sv @@
// Front end: accepts input beats, expands them and keeps the per-string count.
module xte_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i,
  xte_in_if.sink           in_i,
  input  logic             q_ready_i,
  output logic             q_push_o,
  output xte_pkg::xte_job_t q_job_o
);
  import xte_pkg::*;

  logic [15:0] cap_q, cap_d;
  logic [15:0] bw_q, bw_d;
  logic        stop_q, stop_d;

  logic [ExpMax-1:0][7:0] exp_bytes;
  logic [CntW-1:0]        exp_n;
  logic [7:0]             x;
  logic [1:0]             hund;
  logic [6:0]             rem;
  logic [13:0]            tprod;
  logic [3:0]             tens;
  logic [3:0]             ones;

  logic [15:0] bw_eff;
  logic        stop_eff;
  logic [16:0] bw_p1;
  logic [16:0] room;
  logic [CntW-1:0] cnt;
  logic [16:0] bw_new;
  logic        accept;

  assign x = in_i.in_byte;

  // decimal digits for bytes above 127
  always_comb begin
    hund  = (x >= 8'd200) ? 2'd2 : 2'd1;
    rem   = (x >= 8'd200) ? 7'(x - 8'd200) : 7'(x - 8'd100);
    tprod = 14'(rem) * 14'd103;
    tens  = 4'(tprod >> 10);
    ones  = 4'(rem - 7'(tens) * 7'd10);
  end

  always_comb begin
    exp_bytes = '0;
    exp_n     = '0;
    priority if (x == ChLt) begin
      exp_bytes[0] = ChAmp; exp_bytes[1] = 8'h6C; exp_bytes[2] = 8'h74;
      exp_bytes[3] = ChSemi;
      exp_n = 3'd4;
    end else if (x == ChAmp) begin
      exp_bytes[0] = ChAmp; exp_bytes[1] = 8'h61; exp_bytes[2] = 8'h6D;
      exp_bytes[3] = 8'h70; exp_bytes[4] = ChSemi;
      exp_n = 3'd5;
    end else if (x[7]) begin
      exp_bytes[0] = ChAmp; exp_bytes[1] = ChHash;
      exp_bytes[2] = ChZero + 8'(hund);
      exp_bytes[3] = ChZero + 8'(tens);
      exp_bytes[4] = ChZero + 8'(ones);
      exp_bytes[5] = ChSemi;
      exp_n = 3'd6;
    end else if (x == ChTab) begin
      exp_bytes[0] = ChAmp; exp_bytes[1] = ChHash;
      exp_bytes[2] = ChZero + 8'd9; exp_bytes[3] = ChSemi;
      exp_n = 3'd4;
    end else if (x == ChLf || x == ChCr) begin
      exp_bytes[0] = ChAmp; exp_bytes[1] = ChHash;
      exp_bytes[2] = ChZero + 8'd1;
      exp_bytes[3] = (x == ChLf) ? ChZero : ChZero + 8'd3;
      exp_bytes[4] = ChSemi;
      exp_n = 3'd5;
    end else if (x < ChSpc) begin
      exp_n = '0;
    end else begin
      exp_bytes[0] = x;
      exp_n = 3'd1;
    end
  end

  // count and stop check
  always_comb begin
    bw_eff   = in_i.string_start ? '0 : bw_q;
    stop_eff = in_i.string_start ? 1'b0 : stop_q;
    bw_p1    = {1'b0, bw_eff} + 17'd1;
    room     = ({1'b0, cap_q} > bw_p1) ? ({1'b0, cap_q} - bw_p1) : '0;
    cnt      = (room >= 17'(exp_n)) ? exp_n : CntW'(room);
    bw_new   = {1'b0, bw_eff} + 17'(cnt);
  end

  assign in_i.ready = q_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign q_push_o   = accept && !stop_eff && (cnt != '0);

  always_comb begin
    q_job_o.bytes = exp_bytes;
    q_job_o.cnt   = cnt;
    q_job_o.stop  = (bw_new + StopMargin) >= {1'b0, cap_q};
  end

  always_comb begin
    cap_d  = cfg_we_i ? cfg_wdata_i : cap_q;
    bw_d   = bw_q;
    stop_d = stop_q;
    if (accept) begin
      if (stop_eff) begin
        bw_d   = bw_eff;
        stop_d = stop_eff;
      end else begin
        bw_d   = bw_new[15:0];
        stop_d = q_job_o.stop;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CapReset;
      bw_q   <= '0;
      stop_q <= 1'b0;
    end else begin
      cap_q  <= cap_d;
      bw_q   <= bw_d;
      stop_q <= stop_d;
    end
  end

endmodule

@@ rtl/xte_fifo.sv @@
// Short queue of classified items between front and back end.
module xte_fifo #(
  parameter int unsigned Depth = xte_pkg::QDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  xte_pkg::xte_job_t push_job_i,
  output logic              ready_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output xte_pkg::xte_job_t head_job_o
);
  import xte_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntQW = $clog2(Depth + 1);

  xte_job_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntQW-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign ready_o      = (cnt_q != CntQW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_job_o   = mem_q[rd_q];
  assign do_push      = push_i && ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_job_i;
  end

endmodule

@@ rtl/xte_back.sv @@
// Back end: walks the expansion of the head item, one output beat per cycle while out_o.ready holds.
module xte_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  xte_pkg::xte_job_t head_job_i,
  output logic              pop_o,
  xte_out_if.source         out_o
);
  import xte_pkg::*;

  logic [CntW-1:0] idx_q, idx_d;
  logic            valid_q, valid_d;
  logic [7:0]      byte_q;
  logic            last_q;
  logic            stop_q;
  logic            load;
  logic            is_last;

  assign load    = head_valid_i && (!valid_q || out_o.ready);
  assign is_last = (idx_q == head_job_i.cnt - 1'b1);
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = is_last ? '0 : idx_q + 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_job_i.bytes[idx_q];
      last_q <= is_last;
      stop_q <= head_job_i.stop;
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.out_byte         = byte_q;
  assign out_o.run_last         = last_q;
  assign out_o.capacity_reached = stop_q;

endmodule
